>>> rtl/qdsio_pkg.sv
package qdsio_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_DISC  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OFF_DATA_A = 2'd0,
        OFF_DATA_B = 2'd1,
        OFF_CTRL_A = 2'd2,
        OFF_CTRL_B = 2'd3
    } t_off;

    // Write register pointers and command fields
    localparam logic [2:0] WR_CMD        = 3'd0;
    localparam logic [2:0] WR_VECTOR     = 3'd2;
    localparam logic [2:0] WR_RX_CTRL    = 3'd3;
    localparam logic [2:0] WR_TX_CTRL    = 3'd5;
    localparam logic [2:0] WR_SYNC1      = 3'd6;
    localparam logic [2:0] WR_SYNC2      = 3'd7;
    localparam logic [7:0] CMD_FIELD     = 8'h38;
    localparam logic [7:0] CMD_CHAN_RST  = 8'h18;
    localparam logic [7:0] HUNT_ENABLE   = 8'h11;
    localparam logic [7:0] MOTOR_ON      = 8'h80;

    // Status byte bits
    localparam logic [7:0] ST_HUNT       = 8'h10;
    localparam logic [7:0] ST_HUNT_CLR   = 8'hEF;
    localparam logic [7:0] ST_DCD        = 8'h08;
    localparam logic [7:0] ST_DCD_CLR    = 8'hF7;
    localparam logic [7:0] ST_UNDERRUN_CLR = 8'hDF;
    localparam logic [7:0] ST_ALWAYS_SET = 8'h05;

    localparam logic [7:0] RD_IDLE_BYTE  = 8'hFF;
    localparam logic [7:0] RD_NOT_HOME   = 8'h08;
    localparam logic [3:0] HUNT_FETCHES  = 4'd8;

    typedef struct packed {
        logic capture;   // latch the accepted word
        logic exec;      // run the decoded operation
        logic rd;        // issue an image read and advance position
        logic chk;       // evaluate fetched byte
        logic fin;       // build status byte and control A result
        logic push;      // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic need_fetch;
        logic data_a;
        logic ctrl_a_read;
        logic is_read;
        logic chk_done;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/qdsio_ctrl.sv
module qdsio_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  qdsio_pkg::t_dp_sts  i_sts,
    output qdsio_pkg::t_dp_cmd  o_cmd
);
    import qdsio_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_RD   = 6'b000100,
        S_CHK  = 6'b001000,
        S_FIN  = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_sts.need_fetch) n_state = S_RD;
                else if (i_sts.ctrl_a_read)    n_state = S_FIN;
                else if (i_sts.is_read)        n_state = S_RESP;
                else                           n_state = S_IDLE;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                priority if (!i_sts.chk_done) n_state = S_RD;
                else if (i_sts.data_a)        n_state = S_RESP;
                else                          n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/qdsio_dp.sv
module qdsio_dp #(
    parameter int IMAGE_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_s_axis_tuser,
    input  logic [23:0]         i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,
    input  qdsio_pkg::t_dp_cmd  i_cmd,
    output qdsio_pkg::t_dp_sts  o_sts
);
    import qdsio_pkg::*;

    localparam int ADDR_W = $clog2(IMAGE_BYTES);

    // Captured word
    t_cmd        r_cmd;
    t_off        r_off;
    logic [7:0]  r_data;
    logic [15:0] r_addr;

    // Controller state
    logic [7:0]  r_wr [8];
    logic [7:0]  r_status;
    logic [7:0]  r_vector;
    logic [2:0]  r_ptr_a;
    logic [2:0]  r_ptr_b;
    logic [15:0] r_pos;
    logic        r_ready;
    logic        r_home;

    // Fetch and result
    logic [7:0]  r_mem [IMAGE_BYTES];
    logic [7:0]  r_mem_q;
    logic        r_hit;
    logic [7:0]  r_prev;
    logic [3:0]  r_cnt;
    logic [7:0]  r_res;
    logic        r_tvalid;
    logic [7:0]  r_tdata;

    logic [7:0]  fetched;
    logic        sync_match;
    logic        hunt_en;
    logic        load_hit;
    logic        pos_hit;
    logic [7:0]  st_next;

    assign fetched    = r_hit ? r_mem_q : 8'h00;
    assign sync_match = (r_cnt != 4'd0) && (r_prev == r_wr[WR_SYNC1]) &&
                        (fetched == r_wr[WR_SYNC2]);
    assign hunt_en    = ((r_wr[WR_RX_CTRL] & HUNT_ENABLE) == HUNT_ENABLE);
    assign load_hit   = ({16'd0, r_addr} < 32'(IMAGE_BYTES));
    assign pos_hit    = ({16'd0, r_pos} < 32'(IMAGE_BYTES));
    assign st_next    = ((r_status & ST_UNDERRUN_CLR & ST_DCD_CLR) | ST_ALWAYS_SET) |
                        (r_ready ? ST_DCD : 8'h00);

    always_comb begin
        o_sts             = '0;
        o_sts.is_read     = (r_cmd == CMD_READ);
        o_sts.data_a      = o_sts.is_read && (r_off == OFF_DATA_A);
        o_sts.ctrl_a_read = o_sts.is_read && (r_off == OFF_CTRL_A);
        o_sts.need_fetch  = o_sts.data_a || (o_sts.ctrl_a_read && hunt_en);
        o_sts.chk_done    = o_sts.data_a || sync_match || (r_cnt == HUNT_FETCHES);
        o_sts.out_free    = !r_tvalid || i_m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= t_cmd'(i_s_axis_tuser[1:0]);
            r_off  <= t_off'(i_s_axis_tuser[3:2]);
            r_data <= i_s_axis_tdata[7:0];
            r_addr <= i_s_axis_tdata[23:8];
        end
    end

    // Image memory: load port writes, fetch port reads at the position
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_cmd == CMD_LOAD && load_hit) begin
            r_mem[r_addr[ADDR_W-1:0]] <= r_data;
        end
        if (i_cmd.rd) begin
            r_mem_q <= r_mem[r_pos[ADDR_W-1:0]];
            r_hit   <= pos_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_wr[i] <= 8'h00;
            r_status <= 8'h00;
            r_vector <= 8'h00;
            r_ptr_a  <= 3'd0;
            r_ptr_b  <= 3'd0;
            r_pos    <= 16'd0;
            r_ready  <= 1'b0;
            r_home   <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_cmd)
                    CMD_WRITE: begin
                        if (r_off == OFF_CTRL_A) begin
                            if (r_ptr_a == WR_CMD) begin
                                r_ptr_a <= r_data[2:0];
                                if ((r_data & CMD_FIELD) == CMD_CHAN_RST) begin
                                    for (int i = 0; i < 8; i++) r_wr[i] <= 8'h00;
                                end else begin
                                    r_wr[WR_CMD] <= r_data;
                                end
                            end else begin
                                r_wr[r_ptr_a] <= r_data;
                                if (r_ptr_a == WR_RX_CTRL && (r_data & ST_HUNT) != 8'h00)
                                    r_status <= r_status | ST_HUNT;
                                r_ptr_a <= 3'd0;
                            end
                        end else if (r_off == OFF_CTRL_B) begin
                            if (r_ptr_b == WR_CMD) begin
                                r_ptr_b <= r_data[2:0];
                            end else begin
                                if (r_ptr_b == WR_VECTOR) r_vector <= r_data;
                                // motor off: rewind to the start of the image
                                if (r_ptr_b == WR_TX_CTRL && (r_data & MOTOR_ON) == 8'h00) begin
                                    r_pos  <= 16'd0;
                                    r_home <= 1'b1;
                                end
                                r_ptr_b <= 3'd0;
                            end
                        end
                    end
                    CMD_READ: begin
                        if (r_off == OFF_DATA_A) begin
                            r_home <= 1'b0;
                        end else if (r_off == OFF_CTRL_A) begin
                            if (hunt_en) r_status <= r_status | ST_HUNT;
                        end else if (r_off == OFF_CTRL_B) begin
                            r_ptr_b <= 3'd0;
                        end
                    end
                    CMD_LOAD: begin
                    end
                    CMD_DISC: begin
                        if (r_data[0]) begin
                            r_ready <= 1'b1;
                            r_home  <= 1'b1;
                            r_ptr_a <= 3'd0;
                            r_ptr_b <= 3'd0;
                            r_pos   <= 16'd0;
                        end else begin
                            r_ready <= 1'b0;
                            r_home  <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.rd) begin
                r_pos <= r_pos + 16'd1;
            end
            if (i_cmd.chk && sync_match) begin
                r_status <= r_status & ST_HUNT_CLR;
            end
            if (i_cmd.fin) begin
                r_status <= st_next;
                r_ptr_a  <= 3'd0;
            end
        end
    end

    // Result and hunt bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cnt <= 4'd0;
            unique case (r_off)
                OFF_DATA_A: r_res <= 8'h00;
                OFF_DATA_B: r_res <= RD_IDLE_BYTE;
                OFF_CTRL_A: r_res <= 8'h00;
                OFF_CTRL_B: begin
                    if (r_ptr_b == WR_CMD) begin
                        r_res <= RD_IDLE_BYTE;
                    end else begin
                        unique case (r_ptr_b[1:0])
                            2'd0:    r_res <= r_home ? 8'h00 : RD_NOT_HOME;
                            2'd2:    r_res <= r_vector;
                            default: r_res <= 8'h00;
                        endcase
                    end
                end
                default: r_res <= 8'h00;
            endcase
        end
        if (i_cmd.chk) begin
            r_res  <= fetched;
            r_prev <= fetched;
            r_cnt  <= r_cnt + 4'd1;
        end
        if (i_cmd.fin) begin
            r_res <= (r_ptr_a[1:0] == 2'd0) ? st_next : 8'h00;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (i_cmd.push) begin
            r_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_tdata <= r_res;
    end

    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata  = r_tdata;

endmodule

>>> rtl/quick_disk_sio_emulator.sv
// Quick-disk serial controller emulator. One word in, at most one word out:
// each input word is a bus write, a bus read, an image byte load or a disc
// insert/eject, and only bus reads return a byte. Words are taken one at a
// time. A read of data B or control B waits only for output hand-off; a data
// A read also fetches an image byte, and the image memory read is registered.
// A control A read without hunt builds the status byte first. With hunt
// enabled it fetches two to nine image bytes through the single memory read
// port. The image memory holds IMAGE_BYTES bytes and has no reset; only bytes
// that were loaded may be read back.
module quick_disk_sio_emulator #(
    parameter int IMAGE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [7:0] data_in, [23:8] image_addr
    input  logic [3:0]  i_s_axis_tuser,  // [1:0] cmd, [3:2] reg_offset
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // [7:0] read_data
);
    import qdsio_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    qdsio_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (dp_sts),
        .o_cmd           (dp_cmd)
    );

    qdsio_dp #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts)
    );

endmodule

>>> tb/tb.sv
module tb;
    import qdsio_pkg::*;

    localparam int IMG_BYTES    = 65536;
    localparam int RAND_WORDS   = 1050;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        t_cmd        cmd;
        t_off        off;
        logic [7:0]  data;
        logic [15:0] addr;
    } t_qd_word;

    // Shadow of the controller and image; holds the read bytes still owed.
    class qd_sio_shadow;
        logic [7:0]  wr_a [8];
        logic [7:0]  status_a;
        logic [7:0]  vector_b;
        logic [2:0]  ptr_a;
        logic [2:0]  ptr_b;
        logic [15:0] pos;
        logic        disc_in;
        logic        at_home;
        logic [7:0]  image [IMG_BYTES];
        bit          loaded [IMG_BYTES];
        logic [7:0]  read_bytes [$];
        int          errors;

        function new();
            foreach (wr_a[i]) wr_a[i] = 8'h00;
            status_a = 8'h00;
            vector_b = 8'h00;
            ptr_a    = WR_CMD;
            ptr_b    = WR_CMD;
            pos      = 16'h0000;
            disc_in  = 1'b0;
            at_home  = 1'b0;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function logic [7:0] fetch_image();
            logic [7:0] v;
            v = (int'(pos) < IMG_BYTES) ? image[pos] : 8'h00;
            pos = pos + 16'd1;
            return v;
        endfunction

        function void write_ctrl_a(logic [7:0] d);
            logic [2:0] p;
            p = ptr_a;
            wr_a[p] = d;
            if (p == WR_CMD) begin
                ptr_a = d[2:0];
                if ((d & CMD_FIELD) == CMD_CHAN_RST)
                    foreach (wr_a[i]) wr_a[i] = 8'h00;
            end else begin
                if (p == WR_RX_CTRL && (d & ST_HUNT) != 8'h00)
                    status_a = status_a | ST_HUNT;
                ptr_a = WR_CMD;
            end
        endfunction

        function void write_ctrl_b(logic [7:0] d);
            if (ptr_b == WR_CMD) begin
                ptr_b = d[2:0];
            end else begin
                if (ptr_b == WR_VECTOR)
                    vector_b = d;
                // motor off: rewind to the start of the image
                if (ptr_b == WR_TX_CTRL && (d & MOTOR_ON) == 8'h00) begin
                    pos     = 16'h0000;
                    at_home = 1'b1;
                end
                ptr_b = WR_CMD;
            end
        endfunction

        function logic [7:0] bus_read(t_off off);
            logic [7:0] r;
            logic [7:0] prev;
            logic [7:0] nxt;
            bit         found;
            r = RD_IDLE_BYTE;
            case (off)
                OFF_DATA_A: begin
                    at_home = 1'b0;
                    r = fetch_image();
                end
                OFF_CTRL_A: begin
                    if ((wr_a[WR_RX_CTRL] & HUNT_ENABLE) == HUNT_ENABLE) begin
                        status_a = status_a | ST_HUNT;
                        found = 1'b0;
                        prev = fetch_image();
                        for (int i = 0; i < HUNT_FETCHES && !found; i++) begin
                            nxt = fetch_image();
                            if (prev == wr_a[WR_SYNC1] && nxt == wr_a[WR_SYNC2]) begin
                                status_a = status_a & ST_HUNT_CLR;
                                found = 1'b1;
                            end
                            prev = nxt;
                        end
                    end
                    status_a = disc_in ? (status_a | ST_DCD) : (status_a & ST_DCD_CLR);
                    status_a = (status_a & ST_UNDERRUN_CLR) | ST_ALWAYS_SET;
                    r = (ptr_a[1:0] == WR_CMD[1:0]) ? status_a : 8'h00;
                    ptr_a = WR_CMD;
                end
                OFF_CTRL_B: begin
                    if (ptr_b == WR_CMD) begin
                        r = RD_IDLE_BYTE;
                    end else begin
                        case (ptr_b[1:0])
                            WR_CMD[1:0]:    r = at_home ? 8'h00 : RD_NOT_HOME;
                            WR_VECTOR[1:0]: r = vector_b;
                            default:        r = 8'h00;
                        endcase
                    end
                    ptr_b = WR_CMD;
                end
                default: r = RD_IDLE_BYTE;
            endcase
            return r;
        endfunction

        function void note_input(t_qd_word w);
            case (w.cmd)
                CMD_WRITE: begin
                    if (w.off == OFF_CTRL_A)
                        write_ctrl_a(w.data);
                    else if (w.off == OFF_CTRL_B)
                        write_ctrl_b(w.data);
                end
                CMD_READ: read_bytes.push_back(bus_read(w.off));
                CMD_LOAD: begin
                    if (int'(w.addr) < IMG_BYTES) begin
                        image[w.addr]  = w.data;
                        loaded[w.addr] = 1'b1;
                    end
                end
                default: begin
                    if (w.data[0]) begin
                        disc_in = 1'b1;
                        at_home = 1'b1;
                        ptr_a   = WR_CMD;
                        ptr_b   = WR_CMD;
                        pos     = 16'h0000;
                    end else begin
                        disc_in = 1'b0;
                        at_home = 1'b0;
                    end
                end
            endcase
        endfunction

        task check_result(logic [7:0] got);
            logic [7:0] want;
            if (read_bytes.size() == 0) begin
                report($sformatf("read word %02h with none outstanding", got));
            end else begin
                want = read_bytes.pop_front();
                if (got !== want)
                    report($sformatf("read_data %02h, want %02h", got, want));
            end
        endtask

        task flush_check();
            if (read_bytes.size() != 0)
                report($sformatf("%0d read words never returned", read_bytes.size()));
        endtask

        // Most image bytes a word can pull from memory if it is taken now.
        function int fetches_for(t_qd_word w);
            if (w.cmd != CMD_READ)
                return 0;
            if (w.off == OFF_DATA_A)
                return 1;
            if (w.off == OFF_CTRL_A && (wr_a[WR_RX_CTRL] & HUNT_ENABLE) == HUNT_ENABLE)
                return 1 + HUNT_FETCHES;
            return 0;
        endfunction

        function int unwritten_ahead(int n);
            logic [15:0] a;
            for (int i = 0; i < n; i++) begin
                a = pos + 16'(i);
                if (!loaded[a])
                    return int'(a);
            end
            return -1;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // [7:0] data_in, [23:8] image_addr
    logic [3:0]  i_s_axis_tuser;   // [1:0] cmd, [3:2] reg_offset
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;   // [7:0] read_data

    qd_sio_shadow shadow;
    t_qd_word     plan [$];
    t_qd_word     in_word;
    int           results_seen = 0;
    int           idle_cycles  = 0;
    int           sink_stall   = 0;
    bit           held         = 1'b0;
    bit           calm         = 1'b0;

    quick_disk_sio_emulator #(
        .IMAGE_BYTES(IMG_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function int gap_len();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function void put(t_cmd c, t_off o, logic [7:0] d, logic [15:0] a);
        t_qd_word w;
        w.cmd  = c;
        w.off  = o;
        w.data = d;
        w.addr = a;
        plan.push_back(w);
    endfunction

    function void put_wr(t_off o, logic [7:0] d);
        put(CMD_WRITE, o, d, 16'($urandom));
    endfunction

    function void put_rd(t_off o);
        put(CMD_READ, o, 8'($urandom), 16'($urandom));
    endfunction

    function void put_load(logic [7:0] d, logic [15:0] a);
        put(CMD_LOAD, t_off'($urandom_range(0, 3)), d, a);
    endfunction

    // Pointer select for channel A with random upper bits, never a channel reset.
    function logic [7:0] a_pointer_byte(logic [2:0] p);
        logic [7:0] r;
        r = 8'($urandom);
        if ((r & CMD_FIELD) == CMD_CHAN_RST)
            r[3] = ~r[3];
        return {r[7:3], p};
    endfunction

    function void plan_directed();
        put(CMD_DISC, OFF_DATA_A, 8'h01, 16'h0000);
        put_rd(OFF_CTRL_B);
        put_rd(OFF_DATA_B);
        put_wr(OFF_DATA_A, 8'hFF);
        put_load(8'hFF, 16'hFFFF);
        put_load(8'h00, 16'h0000);
        put_wr(OFF_CTRL_B, {5'b00000, WR_VECTOR});
        put_wr(OFF_CTRL_B, 8'hA5);
        put_wr(OFF_CTRL_B, {5'b11111, WR_VECTOR});
        put_rd(OFF_CTRL_B);
        // motor off, then pointer 4 reads the home flag
        put_wr(OFF_CTRL_B, {5'b00000, WR_TX_CTRL});
        put_wr(OFF_CTRL_B, 8'h7F);
        put_wr(OFF_CTRL_B, 8'h04);
        put_rd(OFF_CTRL_B);
        put_wr(OFF_CTRL_B, 8'h07);
        put_rd(OFF_CTRL_B);
        // sync pair placed a few bytes into the image, then hunt
        put_wr(OFF_CTRL_A, {5'b00000, WR_SYNC1});
        put_wr(OFF_CTRL_A, 8'h7E);
        put_wr(OFF_CTRL_A, {5'b00000, WR_SYNC2});
        put_wr(OFF_CTRL_A, 8'h81);
        put_load(8'h7E, 16'd3);
        put_load(8'h81, 16'd4);
        put_wr(OFF_CTRL_A, {5'b00000, WR_RX_CTRL});
        put_wr(OFF_CTRL_A, HUNT_ENABLE);
        put_rd(OFF_CTRL_A);
        put_wr(OFF_CTRL_A, 8'h03);
        put_rd(OFF_CTRL_A);
        put_rd(OFF_DATA_A);
        put_wr(OFF_CTRL_A, CMD_CHAN_RST | 8'hC0);
        put(CMD_DISC, OFF_CTRL_B, 8'hFE, 16'hFFFF);
        put_rd(OFF_CTRL_A);
        put_wr(OFF_CTRL_B, 8'h04);
        put_rd(OFF_CTRL_B);
        put(CMD_DISC, OFF_DATA_B, 8'hFF, 16'h5A5A);
    endfunction

    function void plan_scenario();
        int         roll;
        int         k;
        logic [2:0] p;
        logic [7:0] d;
        logic [7:0] s1;
        logic [7:0] s2;
        // return both pointers to the command register first
        if (shadow.ptr_a != WR_CMD)
            put_rd(OFF_CTRL_A);
        if (shadow.ptr_b != WR_CMD)
            put_rd(OFF_CTRL_B);
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            p = 3'($urandom_range(1, 7));
            d = 8'($urandom);
            if (p == WR_RX_CTRL && $urandom_range(0, 1) == 1)
                d = d | HUNT_ENABLE;
            put_wr(OFF_CTRL_A, a_pointer_byte(p));
            put_wr(OFF_CTRL_A, d);
        end else if (roll < 16) begin
            d = (8'($urandom) & ~CMD_FIELD) | CMD_CHAN_RST;
            put_wr(OFF_CTRL_A, d);
        end else if (roll < 30) begin
            p = 3'($urandom);
            if (p != WR_CMD)
                put_wr(OFF_CTRL_A, a_pointer_byte(p));
            put_rd(OFF_CTRL_A);
        end else if (roll < 40) begin
            p = 3'($urandom_range(1, 7));
            put_wr(OFF_CTRL_B, {5'($urandom), p});
            put_wr(OFF_CTRL_B, 8'($urandom));
        end else if (roll < 52) begin
            p = 3'($urandom);
            put_wr(OFF_CTRL_B, {5'($urandom), p});
            put_rd(OFF_CTRL_B);
        end else if (roll < 64) begin
            repeat ($urandom_range(1, 4)) put_rd(OFF_DATA_A);
        end else if (roll < 76) begin
            s1 = 8'($urandom);
            s2 = 8'($urandom);
            put_wr(OFF_CTRL_A, a_pointer_byte(WR_SYNC1));
            put_wr(OFF_CTRL_A, s1);
            put_wr(OFF_CTRL_A, a_pointer_byte(WR_SYNC2));
            put_wr(OFF_CTRL_A, s2);
            put_wr(OFF_CTRL_A, a_pointer_byte(WR_RX_CTRL));
            put_wr(OFF_CTRL_A, 8'($urandom) | HUNT_ENABLE);
            if ($urandom_range(0, 3) != 0) begin
                // rewind and drop the pair somewhere in the search window
                put_wr(OFF_CTRL_B, {5'($urandom), WR_TX_CTRL});
                put_wr(OFF_CTRL_B, 8'($urandom) & ~MOTOR_ON);
                k = $urandom_range(0, 7);
                put_load(s1, 16'(k));
                put_load(s2, 16'(k + 1));
            end
            put_rd(OFF_CTRL_A);
            if ($urandom_range(0, 1) == 1)
                put_rd(OFF_CTRL_A);
        end else if (roll < 80) begin
            put(CMD_DISC, t_off'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
        end else if (roll < 84) begin
            put_wr(t_off'($urandom_range(0, 1)), 8'($urandom));
            put_rd(OFF_DATA_B);
        end else if (roll < 90) begin
            put_load(8'($urandom), 16'($urandom));
        end else if (roll < 94) begin
            put_wr(OFF_CTRL_B, {5'($urandom), WR_TX_CTRL});
            put_wr(OFF_CTRL_B, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3))
                put(t_cmd'($urandom_range(0, 3)), t_off'($urandom_range(0, 3)),
                    8'($urandom), 16'($urandom));
        end
    endfunction

    function t_qd_word next_word();
        t_qd_word w;
        int       gap;
        while (plan.size() == 0)
            plan_scenario();
        w = plan[0];
        gap = shadow.unwritten_ahead(shadow.fetches_for(w));
        if (gap >= 0) begin
            // fill the image ahead of a read that would fetch from it
            w.cmd  = CMD_LOAD;
            w.off  = t_off'($urandom_range(0, 3));
            w.data = 8'($urandom);
            w.addr = 16'(gap);
        end else begin
            void'(plan.pop_front());
        end
        return w;
    endfunction

    task automatic send_word(t_qd_word w);
        int n;
        n = gap_len();
        if (n > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {w.addr, w.data};
        i_s_axis_tuser  = {w.off, w.cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                in_word.cmd  = t_cmd'(i_s_axis_tuser[1:0]);
                in_word.off  = t_off'(i_s_axis_tuser[3:2]);
                in_word.data = i_s_axis_tdata[7:0];
                in_word.addr = i_s_axis_tdata[23:8];
                shadow.note_input(in_word);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                shadow.check_result(o_m_axis_tdata);
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** quick_disk_sio_emulator: FAILED **");
            $finish;
        end
    end

    // Read side: random stalls, plus one long hold while words keep coming.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                sink_stall = HOLD_CYCLES;
            end
            if (sink_stall > 0) begin
                i_m_axis_tready = 1'b0;
                sink_stall--;
            end else begin
                i_m_axis_tready = 1'b1;
                if ($urandom_range(0, 99) < 20)
                    sink_stall = gap_len();
            end
        end
    end

    initial begin
        int total;
        shadow = new();
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        plan_directed();
        while (plan.size() != 0)
            send_word(next_word());
        for (total = 0; total < RAND_WORDS; total++) begin
            if (total % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_word(next_word());
        end
        i_s_axis_tvalid = 1'b0;

        while (shadow.read_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        shadow.flush_check();
        if (shadow.errors == 0)
            $display("** quick_disk_sio_emulator: PASSED **");
        else
            $display("** quick_disk_sio_emulator: FAILED **");
        $finish;
    end

endmodule
